// ===== hdl/sidq_pkg.sv =====
// shared types and constants for the sorted insert deque
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sidq_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;

   localparam logic [2:0] ACT_PUSH_HEAD = 3'd0;
   localparam logic [2:0] ACT_PUSH_TAIL = 3'd1;
   localparam logic [2:0] ACT_POP_HEAD  = 3'd2;
   localparam logic [2:0] ACT_POP_TAIL  = 3'd3;
   localparam logic [2:0] ACT_INSERT    = 3'd4;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_HEAD,
      CELL_PUSH_TAIL,
      CELL_POP_HEAD,
      CELL_INSERT
   } cell_op_type;

   typedef struct packed {
      cell_op_type                op;
      logic signed [VALUE_W-1:0]  value;
   } cell_ctrl_type;

   typedef struct packed {
      logic occupied;
      logic at_tail;
   } cell_pos_type;

endpackage

`default_nettype wire

// ===== hdl/sidq_cell.sv =====
// one storage cell of the deque chain: holds an entry and trades with its neighbors
// depends on sidq_pkg
`timescale 1ns / 1ps
`default_nettype none

module sidq_cell
   import sidq_pkg::*;
(
   input  wire logic                       clock,
   input  wire cell_ctrl_type              ctrl,
   input  wire cell_pos_type               pos,
   input  wire logic signed [VALUE_W-1:0]  left_entry,
   input  wire logic                       left_found,
   input  wire logic signed [VALUE_W-1:0]  right_entry,
   output logic signed [VALUE_W-1:0]       entry,
   output logic                            found
);

   logic signed [VALUE_W-1:0] entry_ff;
   logic signed [VALUE_W-1:0] entry_in;
   logic                      greater;

   assign greater = pos.occupied && (ctrl.value < entry_ff);
   assign found   = left_found || greater;
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         CELL_PUSH_HEAD: begin
            entry_in = left_entry;
         end
         CELL_PUSH_TAIL: begin
            if (pos.at_tail) begin
               entry_in = ctrl.value;
            end
         end
         CELL_POP_HEAD: begin
            entry_in = right_entry;
         end
         CELL_INSERT: begin
            if (left_found) begin
               entry_in = left_entry;
            end else if (greater || pos.at_tail) begin
               entry_in = ctrl.value;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ===== hdl/sorted_insert_deque_core.sv =====
// sorted insert deque: a chain of compare-and-shift cells with a registered response
// depends on sidq_pkg and sidq_cell
// the response to an accepted request is registered and valid in the cycle after
// one transaction per cycle unless the response is stalled; the cell chain updates on accept
// reset: synchronous, active high; clears the entry count and the response valid
// entry contents are left as they are and only occupied cells are ever read
`timescale 1ns / 1ps
`default_nettype none

module sorted_insert_deque_core
   import sidq_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [2:0]                 req_action,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic signed [VALUE_W-1:0]       rsp_removed_value,
   output logic [COUNT_W-1:0]              rsp_entry_count
);

   logic                       rsp_valid_ff;
   logic [1:0]                 status_ff;
   logic signed [VALUE_W-1:0]  removed_ff;
   logic [COUNT_W-1:0]         count_ff;
   logic [COUNT_W-1:0]         count_in;
   logic [1:0]                 status_in;
   logic signed [VALUE_W-1:0]  removed_in;
   logic                       accept;
   logic                       full;
   logic                       empty;
   logic [IDX_W-1:0]           tail_idx;
   cell_ctrl_type              ctrl;

   logic signed [VALUE_W-1:0]  entry_w [DEPTH];
   logic signed [VALUE_W-1:0]  left_w  [DEPTH];
   logic signed [VALUE_W-1:0]  right_w [DEPTH];
   logic [DEPTH:0]             found_w;
   cell_pos_type               pos_w   [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == COUNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign tail_idx  = IDX_W'(count_ff - COUNT_W'(1));
   assign found_w[0] = 1'b0;

   always_comb begin
      ctrl.op    = CELL_HOLD;
      ctrl.value = req_value;
      count_in   = count_ff;
      status_in  = STATUS_DONE;
      removed_in = '0;
      case (req_action)
         ACT_PUSH_HEAD, ACT_PUSH_TAIL, ACT_INSERT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + COUNT_W'(1);
               case (req_action)
                  ACT_PUSH_HEAD: ctrl.op = CELL_PUSH_HEAD;
                  ACT_PUSH_TAIL: ctrl.op = CELL_PUSH_TAIL;
                  default:       ctrl.op = CELL_INSERT;
               endcase
            end
         end
         ACT_POP_HEAD, ACT_POP_TAIL: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - COUNT_W'(1);
               if (req_action == ACT_POP_HEAD) begin
                  ctrl.op    = CELL_POP_HEAD;
                  removed_in = entry_w[0];
               end else begin
                  removed_in = entry_w[tail_idx];
               end
            end
         end
         default: begin
            ctrl.op = CELL_HOLD;
         end
      endcase
      if (!accept) begin
         ctrl.op  = CELL_HOLD;
         count_in = count_ff;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign pos_w[i].occupied = (COUNT_W'(i) < count_ff);
      assign pos_w[i].at_tail  = (COUNT_W'(i) == count_ff);
      if (i == 0) begin : g_head
         assign left_w[i] = req_value;
      end else begin : g_mid
         assign left_w[i] = entry_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_w[i] = entry_w[i];
      end else begin : g_body
         assign right_w[i] = entry_w[i+1];
      end

      sidq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .pos         (pos_w[i]),
         .left_entry  (left_w[i]),
         .left_found  (found_w[i]),
         .right_entry (right_w[i]),
         .entry       (entry_w[i]),
         .found       (found_w[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
      end
   end

   logic [COUNT_W-1:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_entry_count   = rsp_count_ff;

endmodule

`default_nettype wire

// ===== sim/sidq_reply_checker.sv =====
// response checker for the sorted insert deque: mirrors the store and compares every response
// depends on sidq_pkg; instantiated beside the core by sorted_insert_deque_core_tb
`timescale 1ns / 1ps

module sidq_reply_checker
   import sidq_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [2:0]                  req_action,
   input  logic signed [VALUE_W-1:0]   req_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [1:0]                  rsp_status,
   input  logic signed [VALUE_W-1:0]   rsp_removed_value,
   input  logic [COUNT_W-1:0]          rsp_entry_count,
   output int                          mismatch_count,
   output int                          outstanding
);

   typedef struct packed {
      logic [1:0]                 status;
      logic signed [VALUE_W-1:0]  removed_value;
      logic [COUNT_W-1:0]         entry_count;
   } deque_reply_type;

   logic signed [VALUE_W-1:0] mirror_entries [DEPTH];
   int                        mirror_count;
   deque_reply_type           pending_replies [$];
   int                        fail_total;

   // updates the mirrored store and returns the response the core owes
   function automatic deque_reply_type apply_deque_action(
      input logic [2:0]                action,
      input logic signed [VALUE_W-1:0] value
   );
      deque_reply_type reply;
      int              pos;
      int              i;
      reply.status        = STATUS_DONE;
      reply.removed_value = '0;
      case (action)
         ACT_PUSH_HEAD, ACT_PUSH_TAIL, ACT_INSERT: begin
            if (mirror_count >= DEPTH) begin
               reply.status = STATUS_FULL;
            end else begin
               pos = (action == ACT_PUSH_HEAD) ? 0 : mirror_count;
               // insert goes before the first strictly greater entry
               if (action == ACT_INSERT) begin
                  for (i = mirror_count - 1; i >= 0; i--)
                     if (value < mirror_entries[i]) pos = i;
               end
               for (i = mirror_count; i > pos; i--)
                  mirror_entries[i] = mirror_entries[i - 1];
               mirror_entries[pos] = value;
               mirror_count++;
            end
         end
         ACT_POP_HEAD, ACT_POP_TAIL: begin
            if (mirror_count == 0) begin
               reply.status = STATUS_EMPTY;
            end else if (action == ACT_POP_HEAD) begin
               reply.removed_value = mirror_entries[0];
               for (i = 1; i < mirror_count; i++)
                  mirror_entries[i - 1] = mirror_entries[i];
               mirror_count--;
            end else begin
               reply.removed_value = mirror_entries[mirror_count - 1];
               mirror_count--;
            end
         end
         default: begin
         end
      endcase
      reply.entry_count = COUNT_W'(mirror_count);
      return reply;
   endfunction

   always @(posedge clock) begin : track_replies
      deque_reply_type want;
      deque_reply_type got;
      if (reset) begin
         mirror_count = 0;
         pending_replies.delete();
      end else begin
         if (req_valid && !req_stall)
            pending_replies.push_back(apply_deque_action(req_action, req_value));
         if (rsp_valid && !rsp_stall) begin
            got.status        = rsp_status;
            got.removed_value = rsp_removed_value;
            got.entry_count   = rsp_entry_count;
            if (pending_replies.size() == 0) begin
               if (fail_total < 10)
                  $display("%0t: response with none pending: status %0d removed %0d count %0d",
                           $realtime, got.status, got.removed_value, got.entry_count);
               fail_total++;
            end else begin
               want = pending_replies.pop_front();
               if (got !== want) begin
                  if (fail_total < 10)
                     $display({"%0t: mismatch: expected status %0d removed %0d count %0d, ",
                               "got status %0d removed %0d count %0d"},
                              $realtime, want.status, want.removed_value, want.entry_count,
                              got.status, got.removed_value, got.entry_count);
                  fail_total++;
               end
            end
         end
      end
      mismatch_count <= fail_total;
      outstanding    <= pending_replies.size();
   end

endmodule

// ===== sim/sorted_insert_deque_core_tb.sv =====
// testbench top for sorted_insert_deque_core: drives directed and random transactions
// depends on sidq_pkg, sorted_insert_deque_core and sidq_reply_checker
`timescale 1ns / 1ps

module sorted_insert_deque_core_tb;
   import sidq_pkg::*;

   localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
   localparam logic [2:0] ACT_UNUSED_HI = 3'd7;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [2:0]                 req_action = ACT_PUSH_HEAD;
   logic signed [VALUE_W-1:0]  req_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [1:0]                 rsp_status;
   logic signed [VALUE_W-1:0]  rsp_removed_value;
   logic [COUNT_W-1:0]         rsp_entry_count;
   int                         mismatch_count;
   int                         outstanding;
   int                         send_idle_pct = 28;
   int                         stall_pct = 60;

   sorted_insert_deque_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count)
   );

   sidq_reply_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_entry_count   (rsp_entry_count),
      .mismatch_count    (mismatch_count),
      .outstanding       (outstanding)
   );

   always #1 clock = ~clock;

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   initial begin
      #200000;
      $display("Simulation FAILED");
      $finish;
   end

   task automatic send_transaction(input logic [2:0] action,
                                   input logic signed [VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= action;
      req_value  <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_for_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] random_value();
      case ($urandom_range(3))
         0: return $urandom;
         1: return VALUE_W'($urandom_range(8)) - 4;
         2: begin
            case ($urandom_range(3))
               0: return VALUE_MIN;
               1: return VALUE_MAX;
               2: return '0;
               default: return '1;
            endcase
         end
         default: return VALUE_W'($urandom_range(200)) - 100;
      endcase
   endfunction

   // filling leans toward pushes and inserts, draining toward pops
   function automatic logic [2:0] pick_action(input bit filling);
      int r;
      r = $urandom_range(99);
      if (r < 5) return 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
      if (filling) begin
         if (r < 45) return ACT_INSERT;
         if (r < 60) return ACT_PUSH_HEAD;
         if (r < 75) return ACT_PUSH_TAIL;
         if (r < 88) return ACT_POP_HEAD;
         return ACT_POP_TAIL;
      end
      if (r < 20) return ACT_INSERT;
      if (r < 28) return ACT_PUSH_HEAD;
      if (r < 36) return ACT_PUSH_TAIL;
      if (r < 68) return ACT_POP_HEAD;
      return ACT_POP_TAIL;
   endfunction

   task automatic run_random(input int count);
      int  n;
      int  seg_left;
      bit  filling;
      filling  = 1'b0;
      seg_left = 0;
      for (n = 0; n < count; n++) begin
         if (seg_left == 0) begin
            filling  = !filling;
            seg_left = $urandom_range(15, 50);
         end
         seg_left--;
         send_transaction(pick_action(filling), random_value());
      end
   endtask

   initial begin
      int k;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty store, equal inserts, both ends, unused action codes
      send_transaction(ACT_POP_HEAD, VALUE_MAX);
      send_transaction(ACT_POP_TAIL, '0);
      send_transaction(ACT_INSERT, 5);
      send_transaction(ACT_INSERT, 5);
      send_transaction(ACT_PUSH_HEAD, VALUE_MAX);
      send_transaction(ACT_PUSH_TAIL, VALUE_MIN);
      send_transaction(ACT_UNUSED_LO, -1);
      send_transaction(ACT_UNUSED_HI, 7);
      // fill up, then push and insert when full
      for (k = 0; k < 12; k++)
         send_transaction(ACT_INSERT, random_value());
      send_transaction(ACT_PUSH_HEAD, -2);
      send_transaction(ACT_INSERT, 0);
      send_transaction(ACT_POP_HEAD, '1);
      send_transaction(ACT_POP_TAIL, 3);
      wait_for_replies();

      run_random(230);
      send_idle_pct = 60;
      stall_pct     = 28;
      run_random(230);
      send_idle_pct = 0;
      stall_pct     = 0;
      run_random(230);

      wait_for_replies();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/sidq_pkg.sv
hdl/sidq_cell.sv
hdl/sorted_insert_deque_core.sv
sim/sidq_reply_checker.sv
sim/sorted_insert_deque_core_tb.sv
